// File: rtl/catmull_rom_spline_eval_defines.svh
// assertion macros for the catmull-rom spline evaluator
// expects clk and arst_n in the scope of each use
`ifndef CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH

// same-cycle implication, off while in reset
`define CRS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define CRS_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/crs_pkg.sv
// shared types and constants for the catmull-rom spline evaluator
// no dependencies
package crs_pkg;

	localparam int COORD_W = 32;
	localparam int PARAM_W = 17;
	localparam int COUNT_W = 7;
	localparam int SLOT_W  = 6;
	localparam int FRAC_W  = 16;

	// coefficient and accumulator widths, sized to the worst-case point values
	localparam int E01_W  = 33;
	localparam int E2_W   = 36;
	localparam int ACC_W  = 37;
	localparam int PROD_W = 54;

	localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd4;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;
	localparam logic [PARAM_W-1:0] PARAM_ONE   = 17'h10000;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EVAL  = 1'b1;

	typedef struct packed {
		logic                      action;
		logic [SLOT_W-1:0]         point_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic [PARAM_W-1:0]        curve_param;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] curve_x;
		logic signed [COORD_W-1:0] curve_y;
		logic signed [COORD_W-1:0] curve_z;
	} out_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	// coefficient added after each horner multiply
	typedef enum logic [1:0] {
		STEP_E2 = 2'd0,
		STEP_E1 = 2'd1,
		STEP_E0 = 2'd2
	} horner_step_t;

	typedef struct packed {
		logic         load;
		logic [1:0]   slot;
		logic         coef;
		logic         mul;
		logic         add;
		horner_step_t step;
	} lane_ctl_t;

endpackage

// File: rtl/crs_addr.sv
// segment select: local parameter and the four clamped point slots
// depends on crs_pkg
module crs_addr #(
	parameter int MAX_POINTS = 64
) (
	input  logic [crs_pkg::COUNT_W-1:0]    point_count,
	input  logic [crs_pkg::PARAM_W-1:0]    curve_param,
	output logic [$clog2(MAX_POINTS)-1:0] idx [4],
	output logic [crs_pkg::PARAM_W-1:0]    u
);
	import crs_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int SW = PARAM_W + COUNT_W;

	logic [COUNT_W-1:0]      n;
	logic [COUNT_W-1:0]      n_m1;
	logic [COUNT_W-1:0]      n_m2;
	logic [SW-1:0]           s;
	logic [SW-FRAC_W-1:0]    seg_raw;
	logic [COUNT_W-1:0]      seg;
	logic [SW-1:0]           frac;
	logic [COUNT_W:0]        seg_p1;
	logic [COUNT_W:0]        seg_p2;
	logic [COUNT_W-1:0]      i0;
	logic [COUNT_W:0]        i2;
	logic [COUNT_W:0]        i3;

	always_comb begin
		priority if (point_count < COUNT_MIN) begin
			n = COUNT_MIN;
		end else if (32'(point_count) > MAX_POINTS) begin
			n = COUNT_W'(MAX_POINTS);
		end else begin
			n = point_count;
		end
		n_m1 = n - 7'd1;
		n_m2 = n - 7'd2;

		s       = SW'(curve_param) * SW'(n_m1);
		seg_raw = s[SW-1:FRAC_W];
		if ({1'b0, n_m2} < seg_raw) begin
			seg = n_m2;
		end else begin
			seg = seg_raw[COUNT_W-1:0];
		end

		frac = s - {1'b0, seg, {FRAC_W{1'b0}}};
		if (frac > SW'(PARAM_ONE)) begin
			u = PARAM_ONE;
		end else begin
			u = frac[PARAM_W-1:0];
		end

		// neighbours clamp to the first and last point in use
		seg_p1 = {1'b0, seg} + 8'd1;
		seg_p2 = {1'b0, seg} + 8'd2;
		i0 = (seg == '0) ? '0 : seg - 7'd1;
		i2 = (seg_p1 < {1'b0, n_m1}) ? seg_p1 : {1'b0, n_m1};
		i3 = (seg_p2 < {1'b0, n_m1}) ? seg_p2 : {1'b0, n_m1};

		idx[0] = AW'(i0);
		idx[1] = AW'(seg);
		idx[2] = AW'(i2);
		idx[3] = AW'(i3);
	end

endmodule

// File: rtl/crs_lane.sv
// one coordinate lane: point registers, coefficients and a shared horner multiplier
// depends on crs_pkg
module crs_lane (
	input  logic                              clk,
	input  crs_pkg::lane_ctl_t                ctl,
	input  logic signed [crs_pkg::COORD_W-1:0] rd_coord,
	input  logic [crs_pkg::PARAM_W-1:0]        u,
	output logic signed [crs_pkg::ACC_W-1:0]   acc
);
	import crs_pkg::*;

	localparam int PF_W = ACC_W + PARAM_W + 1;

	logic signed [COORD_W-1:0]     p_q [4];
	logic signed [E2_W-1:0]        x0, x1, x2, x3, d12;
	logic signed [E2_W-1:0]        e3_full, e2_full, e1_full, e0_full;
	logic signed [E2_W-1:0]        e2_q;
	logic signed [E01_W-1:0]       e1_q, e0_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [PF_W-1:0]        prod_full;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [PROD_W-1:0]      rnd_sum;
	logic signed [ACC_W-1:0]       e_sel;

	always_comb begin
		x0  = E2_W'(p_q[0]);
		x1  = E2_W'(p_q[1]);
		x2  = E2_W'(p_q[2]);
		x3  = E2_W'(p_q[3]);
		d12 = x1 - x2;
		e3_full = x3 - x0 + d12 + (d12 <<< 1);
		e2_full = (x0 <<< 1) - (x1 <<< 2) - x1 + (x2 <<< 2) - x3;
		e1_full = x2 - x0;
		e0_full = x1 <<< 1;
	end

	assign prod_full = PF_W'(acc_q) * PF_W'($signed({1'b0, u}));

	// round half up before dropping the fraction
	assign rnd_sum = prod_q + PROD_W'(32'sd32768);

	always_comb begin
		unique case (ctl.step)
			STEP_E2: e_sel = ACC_W'(e2_q);
			STEP_E1: e_sel = ACC_W'(e1_q);
			STEP_E0: e_sel = ACC_W'(e0_q);
			default: e_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			p_q[ctl.slot] <= rd_coord;
		end
		if (ctl.coef) begin
			acc_q <= ACC_W'(e3_full);
			e2_q  <= e2_full;
			e1_q  <= e1_full[E01_W-1:0];
			e0_q  <= e0_full[E01_W-1:0];
		end else if (ctl.add) begin
			acc_q <= $signed(rnd_sum[ACC_W+FRAC_W-1:FRAC_W]) + e_sel;
		end
		if (ctl.mul) begin
			prod_q <= prod_full[PROD_W-1:0];
		end
	end

	assign acc = acc_q;

endmodule

// File: rtl/crs_merge.sv
// merge stage: halves and saturates the three lane results into one output word
// depends on crs_pkg
module crs_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic signed [crs_pkg::ACC_W-1:0]   acc [3],
	output logic                              free,
	output logic                              out_valid,
	input  logic                              out_stall,
	output crs_pkg::out_word_t                out_data
);
	import crs_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	logic               out_valid_q;
	out_word_t          out_data_q;

	function automatic logic signed [COORD_W-1:0] half_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] inc;
		logic signed [ACC_W-1:0] half;
		inc  = a + ACC_W'(1);
		half = inc >>> 1;
		if (half > SAT_HI) begin
			half = SAT_HI;
		end else if (half < SAT_LO) begin
			half = SAT_LO;
		end
		return half[COORD_W-1:0];
	endfunction

	assign free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.curve_x <= half_sat(acc[0]);
			out_data_q.curve_y <= half_sat(acc[1]);
			out_data_q.curve_z <= half_sat(acc[2]);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/catmull_rom_spline_eval.sv
// top level of the catmull-rom spline evaluator: point memory, sequencer, lanes
// depends on crs_pkg, crs_addr, crs_lane, crs_merge and the assertion macro header
//
//   channel | handshake            | word
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_stall  | in_word_t: write point or evaluate at t
//   out     | out_valid / out_stall| out_word_t: interpolated x, y, z
//   cfg     | cfg_valid / cfg_ready| point_count, always ready
//
// a write word is taken while idle; an evaluate word holds the input through four
// reads of the single-port point memory and three multiply/add rounds per lane
// reset clears the sequencer, the output valid and point_count (to 4), not the memory
// a finished result waits in the output register while the next word is accepted;
// the lanes hold their result while that register is still full

`include "catmull_rom_spline_eval_defines.svh"

module catmull_rom_spline_eval #(
	parameter int MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  crs_pkg::in_word_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output crs_pkg::out_word_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [crs_pkg::COUNT_W-1:0]   cfg_data
);
	import crs_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ADDR = 8'b0000_0010,
		ST_READ = 8'b0000_0100,
		ST_FILL = 8'b0000_1000,
		ST_COEF = 8'b0001_0000,
		ST_MUL  = 8'b0010_0000,
		ST_ADD  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t                   state_q;
	logic [1:0]               rd_cnt_q;
	horner_step_t             step_q;
	logic                     rd_valid_s1;
	logic [1:0]               rd_slot_s1;
	point_t                   rd_data_s1;
	logic [COUNT_W-1:0]       count_q;
	logic [PARAM_W-1:0]       t_q;
	logic [AW-1:0]            idx_q [4];
	logic [PARAM_W-1:0]       u_q;
	point_t                   mem_q [MAX_POINTS];

	logic                     in_acc;
	logic                     mem_we;
	logic                     rd_en;
	logic [AW-1:0]            idx [4];
	logic [PARAM_W-1:0]       u;
	lane_ctl_t                lane_ctl;
	logic signed [COORD_W-1:0] rd_coord [3];
	logic signed [ACC_W-1:0]  acc [3];
	logic                     mrg_free;
	logic                     mrg_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign mem_we    = in_acc && (in_data.action == ACT_WRITE)
		&& (32'(in_data.point_index) < MAX_POINTS);
	assign rd_en     = (state_q == ST_READ);
	assign mrg_load  = (state_q == ST_DONE) && mrg_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	crs_addr #(
		.MAX_POINTS (MAX_POINTS)
	) u_addr (
		.point_count (count_q),
		.curve_param (t_q),
		.idx         (idx),
		.u           (u)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			step_q      <= STEP_E2;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_data.action == ACT_EVAL)) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					rd_cnt_q <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd3) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					state_q <= ST_COEF;
				end
				ST_COEF: begin
					step_q  <= STEP_E2;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					unique case (step_q)
						STEP_E2: begin
							step_q  <= STEP_E1;
							state_q <= ST_MUL;
						end
						STEP_E1: begin
							step_q  <= STEP_E0;
							state_q <= ST_MUL;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: begin
					if (mrg_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			t_q <= in_data.curve_param;
		end
		if (state_q == ST_ADDR) begin
			idx_q <= idx;
			u_q   <= u;
		end
		rd_slot_s1 <= rd_cnt_q;
	end

	// point memory, one port: writes only while idle, reads only while sequencing
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[AW'(in_data.point_index)] <= '{
				x: in_data.point_x, y: in_data.point_y, z: in_data.point_z};
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[idx_q[rd_cnt_q]];
		end
	end

	always_comb begin
		lane_ctl      = '0;
		lane_ctl.load = rd_valid_s1;
		lane_ctl.slot = rd_slot_s1;
		lane_ctl.coef = (state_q == ST_COEF);
		lane_ctl.mul  = (state_q == ST_MUL);
		lane_ctl.add  = (state_q == ST_ADD);
		lane_ctl.step = step_q;
	end

	assign rd_coord[0] = rd_data_s1.x;
	assign rd_coord[1] = rd_data_s1.y;
	assign rd_coord[2] = rd_data_s1.z;

	for (genvar g = 0; g < 3; g++) begin : g_lane
		crs_lane u_lane (
			.clk      (clk),
			.ctl      (lane_ctl),
			.rd_coord (rd_coord[g]),
			.u        (u_q),
			.acc      (acc[g])
		);
	end

	crs_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (mrg_load),
		.acc       (acc),
		.free      (mrg_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`CRS_ASSERT_IMP(a_port_conflict, rd_en, !mem_we, "point memory read and write in one cycle")
	`CRS_ASSERT_IMP(a_load_window, rd_valid_s1, state_q == ST_READ || state_q == ST_FILL,
		"lane point load outside the read window")
	`CRS_ASSERT_IMP(a_merge_room, mrg_load, !out_valid || !out_stall,
		"merge loaded over a result still held")
	`CRS_ASSERT_NXT(a_done_out, mrg_load, out_valid && state_q == ST_IDLE,
		"finished evaluation did not reach the output")
	`CRS_ASSERT_NXT(a_eval_start, in_acc && in_data.action == ACT_EVAL, state_q == ST_ADDR,
		"evaluate word did not start the sequencer")

endmodule

// File: dv/crs_curve_checker.sv
`timescale 1ns / 1ps
// checker for the catmull-rom spline evaluator: keeps its own point table and point count,
// predicts each curve point from the accepted words and checks the output words in order
// depends on crs_pkg
module crs_curve_checker #(
	parameter int MAX_POINTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  crs_pkg::in_word_t           in_data,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  crs_pkg::out_word_t          out_data,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [crs_pkg::COUNT_W-1:0] cfg_data,
	output int                          fail_count,
	output int                          pending
);
	import crs_pkg::*;

	point_t             point_table [MAX_POINTS];
	logic [COUNT_W-1:0] point_count;
	out_word_t          expected_points [$];
	int                 mismatches;

	// round half up while dropping sixteen fraction bits
	function automatic longint round_q16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic logic [COORD_W-1:0] blend_axis(logic signed [COORD_W-1:0] c0,
			logic signed [COORD_W-1:0] c1, logic signed [COORD_W-1:0] c2,
			logic signed [COORD_W-1:0] c3, longint u);
		longint p0, p1, p2, p3, e3, e2, e1, e0, acc;
		p0 = c0;
		p1 = c1;
		p2 = c2;
		p3 = c3;
		e3 = -p0 + 3 * p1 - 3 * p2 + p3;
		e2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		e1 = p2 - p0;
		e0 = 2 * p1;
		acc = e3;
		acc = round_q16(acc * u) + e2;
		acc = round_q16(acc * u) + e1;
		acc = round_q16(acc * u) + e0;
		acc = (acc + 1) >>> 1;
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		else if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		return acc[COORD_W-1:0];
	endfunction

	function automatic out_word_t eval_curve_point(logic [PARAM_W-1:0] t);
		int        n, s, seg, u;
		int        idx [4];
		point_t    p [4];
		out_word_t r;
		n = int'(point_count);
		if (n < 4)
			n = 4;
		if (n > MAX_POINTS)
			n = MAX_POINTS;
		s = int'(t) * (n - 1);
		seg = s / 65536;
		if (seg > n - 2)
			seg = n - 2;
		u = s - seg * 65536;
		if (u > 65536)
			u = 65536;
		// neighbours clamped at both ends of the table
		idx[0] = (seg == 0) ? 0 : seg - 1;
		idx[1] = seg;
		idx[2] = (seg + 1 < n - 1) ? seg + 1 : n - 1;
		idx[3] = (seg + 2 < n - 1) ? seg + 2 : n - 1;
		for (int k = 0; k < 4; k++)
			p[k] = point_table[idx[k]];
		r.curve_x = blend_axis(p[0].x, p[1].x, p[2].x, p[3].x, u);
		r.curve_y = blend_axis(p[0].y, p[1].y, p[2].y, p[3].y, u);
		r.curve_z = blend_axis(p[0].z, p[1].z, p[2].z, p[3].z, u);
		return r;
	endfunction

	task automatic check_axis(string axis, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, axis, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			point_count = COUNT_RESET;
			expected_points.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected output word, expected none actual %h",
						$time, out_data);
				end else begin
					want = expected_points.pop_front();
					check_axis("curve_x", want.curve_x, out_data.curve_x);
					check_axis("curve_y", want.curve_y, out_data.curve_y);
					check_axis("curve_z", want.curve_z, out_data.curve_z);
				end
			end
			if (cfg_valid && cfg_ready)
				point_count = cfg_data;
			if (in_valid && !in_stall) begin
				if (in_data.action == ACT_WRITE) begin
					if (in_data.point_index < MAX_POINTS)
						point_table[in_data.point_index] = '{x: in_data.point_x,
							y: in_data.point_y, z: in_data.point_z};
				end else begin
					expected_points.push_back(eval_curve_point(in_data.curve_param));
				end
			end
			fail_count <= mismatches;
			pending <= expected_points.size();
		end
	end

endmodule

// File: dv/tb_catmull_rom_spline_eval.sv
`timescale 1ns / 1ps
// testbench top for the catmull-rom spline evaluator: drives point writes, evaluations
// and point_count settings under varying idle and stall patterns, gives the verdict
// depends on crs_pkg, catmull_rom_spline_eval and crs_curve_checker
module tb_catmull_rom_spline_eval;
	import crs_pkg::*;

	localparam int     MAX_POINTS  = 64;
	localparam int     PHASES      = 10;
	localparam int     RUN_ITEMS   = 105;
	localparam longint CYCLE_LIMIT = 400000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_word_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_word_t          out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data;

	int                    fail_count;
	int                    pending;
	int                    send_idle_pct  = 0;
	int                    recv_stall_pct = 0;
	int                    active_count   = 4;
	longint                cycle_count    = 0;
	logic [MAX_POINTS-1:0] slot_written;

	catmull_rom_spline_eval #(.MAX_POINTS(MAX_POINTS)) u_dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	crs_curve_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.cfg_valid, .cfg_ready, .cfg_data,
		.fail_count, .pending
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [COORD_W-1:0] rand_coord();
		logic [COORD_W-1:0] v;
		v = $urandom;
		unique case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return {{11{v[20]}}, v[20:0]};
			default: return v;
		endcase
	endfunction

	// biased towards segment boundaries and the ends of the curve
	function automatic logic [PARAM_W-1:0] pick_param();
		int k;
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return PARAM_ONE;
			2: return PARAM_W'($urandom_range(65537, 131071));
			3: begin
				k = $urandom_range(1, active_count - 2);
				return PARAM_W'((k * 65536) / (active_count - 1)
					+ int'($urandom_range(0, 2)) - 1);
			end
			default: return PARAM_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic in_word_t point_word(int slot, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
		in_word_t w;
		w.action      = ACT_WRITE;
		w.point_index = SLOT_W'(slot);
		w.point_x     = x;
		w.point_y     = y;
		w.point_z     = z;
		w.curve_param = PARAM_W'($urandom_range(0, 131071));
		return w;
	endfunction

	// the unused fields of an evaluate word carry random junk
	function automatic in_word_t eval_word(logic [PARAM_W-1:0] t);
		in_word_t w;
		w = point_word($urandom_range(0, 63), $urandom, $urandom, $urandom);
		w.action      = ACT_EVAL;
		w.curve_param = t;
		return w;
	endfunction

	task automatic send_word(in_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (w.action == ACT_WRITE)
			slot_written[w.point_index] = 1'b1;
	endtask

	// stop sending, wait for every outstanding point, then let the block go quiet
	task automatic settle(int quiet_cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (quiet_cycles)
			@(posedge clk);
	endtask

	task automatic write_count(logic [COUNT_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		active_count = (v < 4) ? 4 : (v > MAX_POINTS) ? MAX_POINTS : v;
	endtask

	initial begin
		logic [COUNT_W-1:0] phase_count;
		logic [COUNT_W-1:0] phase_counts [PHASES];
		phase_counts = '{7'd64, 7'd5, 7'd0, 7'd127, 7'd4, 7'd3, 7'd100, 7'd65, 7'd0, 7'd0};
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		out_stall    = 1'b0;
		slot_written = '0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// alternating extremes drive the overshoot into saturation
		send_word(point_word(0, 32'h7fff_ffff, 32'h8000_0000, '0));
		send_word(point_word(1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
		send_word(point_word(2, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000));
		send_word(point_word(3, 32'h8000_0000, 32'h7fff_ffff, rand_coord()));
		send_word(eval_word('0));
		send_word(eval_word(17'd1));
		send_word(eval_word(17'd16384));
		send_word(eval_word(17'd21845));
		send_word(eval_word(17'd21846));
		send_word(eval_word(17'd32768));
		send_word(eval_word(17'd43690));
		send_word(eval_word(17'd43691));
		send_word(eval_word(17'd65535));
		send_word(eval_word(PARAM_ONE));
		send_word(eval_word(17'd65537));
		send_word(eval_word(17'h1ffff));
		// evaluate straight after overwriting a point in use
		send_word(point_word(1, rand_coord(), rand_coord(), rand_coord()));
		send_word(eval_word(17'd32768));
		send_word(point_word(63, rand_coord(), rand_coord(), rand_coord()));

		for (int ph = 0; ph < PHASES; ph++) begin
			phase_count = (ph == PHASES - 2) ? 7'($urandom_range(4, 64)) :
				(ph == PHASES - 1) ? 7'($urandom_range(0, 127)) : phase_counts[ph];
			settle(20);
			write_count(phase_count);
			unique case (ph % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 76;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 76;
				end
				default: begin
					send_idle_pct  = 17;
					recv_stall_pct = 17;
				end
			endcase
			// every slot the curve can read must hold a point first
			for (int k = 0; k < active_count; k++)
				if (!slot_written[k])
					send_word(point_word(k, rand_coord(), rand_coord(), rand_coord()));
			for (int i = 0; i < RUN_ITEMS; i++) begin
				if (i == RUN_ITEMS / 2)
					settle(0);
				if ($urandom_range(0, 99) < 55)
					send_word(eval_word(pick_param()));
				else
					send_word(point_word($urandom_range(0, 63), rand_coord(), rand_coord(),
						rand_coord()));
			end
		end

		settle(40);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: catmull_rom_spline_eval.f
+incdir+rtl
rtl/crs_pkg.sv
rtl/crs_addr.sv
rtl/crs_lane.sv
rtl/crs_merge.sv
rtl/catmull_rom_spline_eval.sv
dv/crs_curve_checker.sv
dv/tb_catmull_rom_spline_eval.sv
